// File: rtl/icmp_echo_reply_responder_top_macros.svh
// ----------------------------------------------------------------------------
// ICMP echo responder assertion macros
// Concurrent assertion helpers clocked by clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ICMP_ECHO_REPLY_RESPONDER_TOP_MACROS_SVH
`define ICMP_ECHO_REPLY_RESPONDER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ICMPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ICMPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/icmpr_pkg.sv
// ----------------------------------------------------------------------------
// ICMP echo responder package
// Request and result types, frame offsets and the ones-complement adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package icmpr_pkg;

  localparam int unsigned DEF_BUFFER_DEPTH   = 2048;
  localparam int unsigned DEF_ICMP_SUM_BYTES = 64;
  localparam logic [7:0]  TTL_RESET          = 8'd64;

  // Request and result codes.
  localparam logic REQ_LOAD     = 1'b0;
  localparam logic REQ_READ     = 1'b1;
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  // Header values that make a frame an echo request.
  localparam logic [15:0] ETHERTYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  IP_PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'd8;

  // Byte offsets within the frame (20-byte IP header assumed).
  localparam int unsigned OFS_MAC_SRC   = 6;
  localparam int unsigned OFS_ETYPE     = 12;
  localparam int unsigned OFS_IP_HDR    = 14;
  localparam int unsigned OFS_TTL       = 22;
  localparam int unsigned OFS_PROTO     = 23;
  localparam int unsigned OFS_IP_CSUM   = 24;
  localparam int unsigned OFS_IP_SRC    = 26;
  localparam int unsigned OFS_IP_DST    = 30;
  localparam int unsigned OFS_ICMP      = 34;
  localparam int unsigned OFS_ICMP_CSUM = 36;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic [10:0] read_index;
  } icmpr_in_t;

  typedef struct packed {
    logic        result_kind;
    logic        verdict;
    logic [11:0] frame_length;
    logic [7:0]  read_byte;
  } icmpr_out_t;

  // Ones-complement addition with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] acc, input logic [15:0] v);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, v};
    return s[16] ? (s[15:0] + 16'd1) : s[15:0];
  endfunction

endpackage

// File: rtl/icmpr_ram.sv
// ----------------------------------------------------------------------------
// ICMP echo responder RAM
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icmpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/icmp_echo_reply_responder_top.sv
// ----------------------------------------------------------------------------
// ICMP echo responder top level.
// A request is taken when in_valid and in_ready are both high; a request with a
// result passes the read stage and the output register and is then offered.
// Loads stream at one per cycle while in_ready is high. Requests with a result
// cannot always sustain that rate, as in_ready drops while the read stage and output register are full.
// Reset (rst_n low, synchronous) clears the frame state and sets TTL to 64.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icmp_echo_reply_responder_top #(
  parameter int unsigned BUFFER_DEPTH   = icmpr_pkg::DEF_BUFFER_DEPTH,
  parameter int unsigned ICMP_SUM_BYTES = icmpr_pkg::DEF_ICMP_SUM_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  icmpr_pkg::icmpr_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output icmpr_pkg::icmpr_out_t out_data,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata
);

  import icmpr_pkg::*;

`include "icmp_echo_reply_responder_top_macros.svh"

  // Address width of the frame RAM and width of the byte counter, which must
  // be able to hold the full depth itself.
  localparam int unsigned AW       = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW       = $clog2(BUFFER_DEPTH + 1);
  // Positions and read indexes are compared in a width that holds both the
  // counter and the 11-bit read index; the end of the ICMP sum fits in 11 bits.
  localparam int unsigned CMPW     = (CW > 11) ? CW : 11;
  localparam int unsigned ICMP_END = OFS_ICMP + ICMP_SUM_BYTES;

  function automatic logic [CMPW-1:0] ofs(input int unsigned o);
    return CMPW'(o);
  endfunction

  // --------------------------------------------------------------------------
  // Frame state. The byte store lives in the RAM; everything gathered while
  // the frame loads lives in the registers below.
  // --------------------------------------------------------------------------
  logic [CW-1:0] load_count_r, load_count_nxt;
  logic [15:0]   ether_r, ether_nxt;
  logic [7:0]    proto_r, proto_nxt;
  logic [7:0]    itype_r, itype_nxt;
  logic [15:0]   icmp_sum_r, icmp_sum_nxt;
  logic [15:0]   ip_sum_r, ip_sum_nxt;
  logic          reply_r, reply_nxt;
  logic          ovf_r, ovf_nxt;
  logic          closed_r, closed_nxt;
  logic [7:0]    ttl_r;

  // Read stage (RAM data arrives here) and output register.
  logic       s1_valid_r;
  logic       s1_use_ram_r;
  icmpr_out_t s1_data_r;
  logic       out_valid_r;
  icmpr_out_t out_data_r;

  logic       accept, load_acc, read_acc, result_acc, s1_adv;

  // The input side is held off only when both the read stage and the output
  // register are occupied; otherwise the read stage can always move on.
  assign in_ready   = !s1_valid_r || !out_valid_r;
  assign accept     = in_valid && in_ready;
  assign load_acc   = accept && (in_data.req_type == REQ_LOAD);
  assign read_acc   = accept && (in_data.req_type == REQ_READ);
  assign result_acc = read_acc || (load_acc && in_data.last_byte);
  assign s1_adv     = s1_valid_r && (!out_valid_r || out_ready);

  // --------------------------------------------------------------------------
  // Load path. The first load after a verdict starts a fresh frame, so the
  // current values are replaced by cleared ones before the byte is absorbed.
  // Each header field and checksum word is picked up as its byte goes by.
  // --------------------------------------------------------------------------
  logic [CW-1:0]   base_count;
  logic [CMPW-1:0] pos_w;
  logic            has_space;
  logic [15:0]     sum_word;
  logic            ip_hit, icmp_hit;

  assign base_count = closed_r ? '0 : load_count_r;
  assign pos_w      = CMPW'(base_count);
  assign has_space  = base_count < CW'(BUFFER_DEPTH);
  // Even positions carry the high byte of a 16-bit checksum word.
  assign sum_word   = base_count[0] ? {8'h00, in_data.frame_byte}
                                    : {in_data.frame_byte, 8'h00};

  // The IP sum skips TTL and the checksum; TTL is added back at read time
  // with the configured reply value.
  assign ip_hit = (pos_w >= ofs(OFS_IP_HDR)) && (pos_w < ofs(OFS_ICMP)) &&
                  (pos_w != ofs(OFS_TTL)) && (pos_w != ofs(OFS_IP_CSUM)) &&
                  (pos_w != ofs(OFS_IP_CSUM + 1));
  // The ICMP sum skips the type byte and the checksum.
  assign icmp_hit = (pos_w > ofs(OFS_ICMP)) && (pos_w < ofs(ICMP_END)) &&
                    (pos_w != ofs(OFS_ICMP_CSUM)) && (pos_w != ofs(OFS_ICMP_CSUM + 1));

  always_comb begin
    load_count_nxt = load_count_r;
    ether_nxt      = ether_r;
    proto_nxt      = proto_r;
    itype_nxt      = itype_r;
    icmp_sum_nxt   = icmp_sum_r;
    ip_sum_nxt     = ip_sum_r;
    reply_nxt      = reply_r;
    ovf_nxt        = ovf_r;
    closed_nxt     = closed_r;
    if (load_acc) begin
      load_count_nxt = base_count;
      ether_nxt      = closed_r ? '0 : ether_r;
      proto_nxt      = closed_r ? '0 : proto_r;
      itype_nxt      = closed_r ? '0 : itype_r;
      icmp_sum_nxt   = closed_r ? '0 : icmp_sum_r;
      ip_sum_nxt     = closed_r ? '0 : ip_sum_r;
      reply_nxt      = closed_r ? 1'b0 : reply_r;
      ovf_nxt        = closed_r ? 1'b0 : ovf_r;
      closed_nxt     = 1'b0;
      if (has_space) begin
        if (pos_w == ofs(OFS_ETYPE)) begin
          ether_nxt[15:8] = in_data.frame_byte;
        end
        if (pos_w == ofs(OFS_ETYPE + 1)) begin
          ether_nxt[7:0] = in_data.frame_byte;
        end
        if (pos_w == ofs(OFS_PROTO)) begin
          proto_nxt = in_data.frame_byte;
        end
        if (pos_w == ofs(OFS_ICMP)) begin
          itype_nxt = in_data.frame_byte;
        end
        if (ip_hit) begin
          ip_sum_nxt = oc_add(ip_sum_nxt, sum_word);
        end
        if (icmp_hit) begin
          icmp_sum_nxt = oc_add(icmp_sum_nxt, sum_word);
        end
        load_count_nxt = base_count + 1'b1;
      end else begin
        // Bytes past the end of the buffer are dropped and the frame passes.
        ovf_nxt = 1'b1;
      end
      if (in_data.last_byte) begin
        closed_nxt = 1'b1;
        reply_nxt  = !ovf_nxt &&
                     (CMPW'(load_count_nxt) >= ofs(ICMP_END)) &&
                     (ether_nxt == ETHERTYPE_IPV4) &&
                     (proto_nxt == IP_PROTO_ICMP) &&
                     (itype_nxt == ICMP_ECHO_REQUEST);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Read path. Rewritten bytes that do not come from the store (TTL, both
  // checksums, the ICMP type, anything past the frame) are settled here at
  // acceptance; swapped addresses are remapped before the RAM read.
  // --------------------------------------------------------------------------
  logic [CMPW-1:0] idx_w;
  logic [CMPW-1:0] raddr_w;
  logic            use_ram;
  logic [7:0]      fixed_byte;
  logic [15:0]     ip_ck, icmp_ck;

  assign idx_w   = CMPW'(in_data.read_index);
  assign ip_ck   = ~oc_add(ip_sum_r, {ttl_r, 8'h00});
  assign icmp_ck = ~icmp_sum_r;

  always_comb begin
    raddr_w    = idx_w;
    use_ram    = 1'b1;
    fixed_byte = 8'h00;
    if (idx_w >= CMPW'(load_count_r)) begin
      use_ram = 1'b0;
    end else if (reply_r) begin
      if (idx_w < ofs(OFS_MAC_SRC)) begin
        raddr_w = idx_w + ofs(OFS_MAC_SRC);
      end else if (idx_w < ofs(OFS_ETYPE)) begin
        raddr_w = idx_w - ofs(OFS_MAC_SRC);
      end else if (idx_w == ofs(OFS_TTL)) begin
        use_ram    = 1'b0;
        fixed_byte = ttl_r;
      end else if (idx_w == ofs(OFS_IP_CSUM)) begin
        use_ram    = 1'b0;
        fixed_byte = ip_ck[15:8];
      end else if (idx_w == ofs(OFS_IP_CSUM + 1)) begin
        use_ram    = 1'b0;
        fixed_byte = ip_ck[7:0];
      end else if (idx_w >= ofs(OFS_IP_SRC) && idx_w < ofs(OFS_IP_DST)) begin
        raddr_w = idx_w + ofs(OFS_IP_DST - OFS_IP_SRC);
      end else if (idx_w >= ofs(OFS_IP_DST) && idx_w < ofs(OFS_ICMP)) begin
        raddr_w = idx_w - ofs(OFS_IP_DST - OFS_IP_SRC);
      end else if (idx_w == ofs(OFS_ICMP)) begin
        // The echo reply type is zero.
        use_ram = 1'b0;
      end else if (idx_w == ofs(OFS_ICMP_CSUM)) begin
        use_ram    = 1'b0;
        fixed_byte = icmp_ck[15:8];
      end else if (idx_w == ofs(OFS_ICMP_CSUM + 1)) begin
        use_ram    = 1'b0;
        fixed_byte = icmp_ck[7:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Frame store. Writes happen at the load's acceptance edge and reads at the
  // read's acceptance edge, so a read always sees every earlier load.
  // --------------------------------------------------------------------------
  logic [7:0] ram_rdata;

  icmpr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_frame_ram (
    .clk   (clk),
    .we    (load_acc && has_space),
    .waddr (AW'(base_count)),
    .wdata (in_data.frame_byte),
    .re    (read_acc),
    .raddr (AW'(raddr_w)),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Control registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
      ether_r      <= '0;
      proto_r      <= '0;
      itype_r      <= '0;
      icmp_sum_r   <= '0;
      ip_sum_r     <= '0;
      reply_r      <= 1'b0;
      ovf_r        <= 1'b0;
      closed_r     <= 1'b0;
      ttl_r        <= TTL_RESET;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      load_count_r <= load_count_nxt;
      ether_r      <= ether_nxt;
      proto_r      <= proto_nxt;
      itype_r      <= itype_nxt;
      icmp_sum_r   <= icmp_sum_nxt;
      ip_sum_r     <= ip_sum_nxt;
      reply_r      <= reply_nxt;
      ovf_r        <= ovf_nxt;
      closed_r     <= closed_nxt;
      if (cfg_we) begin
        ttl_r <= cfg_wdata;
      end
      if (result_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result payload registers. A verdict carries the updated frame state; a
  // read answer carries the state as it was when the request arrived.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (result_acc) begin
      if (read_acc) begin
        s1_use_ram_r <= use_ram;
        s1_data_r    <= '{result_kind:  KIND_READ,
                          verdict:      reply_r,
                          frame_length: 12'(load_count_r),
                          read_byte:    fixed_byte};
      end else begin
        s1_use_ram_r <= 1'b0;
        s1_data_r    <= '{result_kind:  KIND_VERDICT,
                          verdict:      reply_nxt,
                          frame_length: 12'(load_count_nxt),
                          read_byte:    8'h00};
      end
    end
    if (s1_adv) begin
      out_data_r <= '{result_kind:  s1_data_r.result_kind,
                      verdict:      s1_data_r.verdict,
                      frame_length: s1_data_r.frame_length,
                      read_byte:    s1_use_ram_r ? ram_rdata : s1_data_r.read_byte};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `ICMPR_ASSERT_NOW(a_count_bound, 1'b1, load_count_r <= CW'(BUFFER_DEPTH),
    "load count exceeds buffer depth")
  `ICMPR_ASSERT_NOW(a_ovf_full, ovf_r, load_count_r == CW'(BUFFER_DEPTH),
    "overflow flagged while buffer not full")
  `ICMPR_ASSERT_NOW(a_reply_closed, reply_r, closed_r && !ovf_r,
    "reply verdict on an open or overflowed frame")
  `ICMPR_ASSERT_NEXT(a_result_staged, result_acc, s1_valid_r,
    "accepted request with a result did not reach the read stage")

endmodule
